FILE: design/pss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pss_pkg
// Shared types, constants and helpers for the PWM soft start sequencer.
// ----------------------------------------------------------------------------
package pss_pkg;

  // ramp geometry
  localparam int unsigned RampSteps = 20;
  localparam int unsigned StepW     = 6;
  localparam int unsigned MsW       = 6;
  localparam int unsigned RepeatW   = 8;
  localparam int unsigned FlashW    = 12;
  localparam int unsigned LedW      = 6;
  localparam int unsigned ChoiceW   = 2;

  localparam logic [StepW-1:0] RampLast = StepW'(RampSteps);

  // bar LED thresholds on the finished step index
  localparam logic [StepW-1:0] Bar1Max = StepW'(4);
  localparam logic [StepW-1:0] Bar2Max = StepW'(8);
  localparam logic [StepW-1:0] Bar3Max = StepW'(12);
  localparam logic [StepW-1:0] Bar4Max = StepW'(16);

  // register reset values
  localparam logic [RepeatW-1:0] PresetARst = 8'd12;
  localparam logic [RepeatW-1:0] PresetBRst = 8'd20;
  localparam logic [RepeatW-1:0] PresetCRst = 8'd27;
  localparam logic [RepeatW-1:0] PresetDRst = 8'd35;
  localparam logic [FlashW-1:0]  FlashMsRst = 12'd1000;

  // configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PRESET_A = 3'd0,
    REG_PRESET_B = 3'd1,
    REG_PRESET_C = 3'd2,
    REG_PRESET_D = 3'd3,
    REG_FLASH_MS = 3'd4
  } reg_idx_e;

  // stream word widths
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 16;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_ON    = 2'd1,
    MODE_RAMP  = 2'd2,
    MODE_FLASH = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e               mode;
    logic                on_flag;
    logic [StepW-1:0]    step_index;
    logic [RepeatW-1:0]  period_repeat;
    logic [MsW-1:0]      ms_in_period;
    logic [FlashW-1:0]   flash_count;
    logic [ChoiceW-1:0]  choice_index;
    logic                direct_pending;
    logic [LedW-1:0]     led_reg;
  } state_t;

  typedef struct packed {
    logic [3:0][RepeatW-1:0] presets;
    logic [FlashW-1:0]       flash_ms;
  } cfg_t;

  typedef struct packed {
    logic time_press;
    logic soft_press;
    logic direct_press;
    logic tick_ms;
  } evt_t;

  typedef struct packed {
    logic [ChoiceW-1:0] time_choice;
    logic               flashing;
    logic               ramping;
    logic               running;
    logic [LedW-1:0]    led_bits;
  } result_t;

  // indicator LED for a time choice
  function automatic logic [LedW-1:0] flash_bit(input logic [ChoiceW-1:0] c);
    logic [LedW-1:0] b;
    unique case (c)
      2'd0:    b = 6'b000100;
      2'd1:    b = 6'b100000;
      2'd2:    b = 6'b010000;
      default: b = 6'b001000;
    endcase
    return b;
  endfunction

endpackage

FILE: design/pss_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pss_step
// Next-state and result logic for one accepted word of button events.
// ----------------------------------------------------------------------------
module pss_step (
  input  pss_pkg::state_t  state_i,
  input  pss_pkg::cfg_t    cfg_i,
  input  pss_pkg::evt_t    evt_i,
  output pss_pkg::state_t  state_o,
  output pss_pkg::result_t result_o
);
  import pss_pkg::*;

  state_t              st;
  logic [LedW-1:0]     leds;
  logic [RepeatW-1:0]  preset;
  logic [RepeatW:0]    rep_inc;

  assign preset  = cfg_i.presets[state_i.choice_index];
  assign rep_inc = {1'b0, state_i.period_repeat} + {{RepeatW{1'b0}}, 1'b1};

  // events act in order: tick, direct, time, soft
  always_comb begin
    st = state_i;

    // tick advances a ramp or a flash
    if (evt_i.tick_ms) begin
      if (st.mode == MODE_RAMP) begin
        if (st.ms_in_period < MsW'(RampSteps)) begin
          st.ms_in_period = st.ms_in_period + MsW'(1);
        end else begin
          st.ms_in_period = '0;
          if (st.direct_pending) begin
            st.mode           = MODE_OFF;
            st.on_flag        = 1'b0;
            st.led_reg        = '0;
            st.direct_pending = 1'b0;
          end else if (rep_inc < {1'b0, preset}) begin
            st.period_repeat = rep_inc[RepeatW-1:0];
          end else begin
            st.period_repeat = '0;
            priority if (st.step_index <= Bar1Max) begin
              st.led_reg[1] = 1'b1;
            end else if (st.step_index <= Bar2Max) begin
              st.led_reg[2] = 1'b1;
            end else if (st.step_index <= Bar3Max) begin
              st.led_reg[3] = 1'b1;
            end else if (st.step_index <= Bar4Max) begin
              st.led_reg[4] = 1'b1;
            end else begin
              // past the last bar threshold nothing more lights
            end
            st.step_index = st.step_index + StepW'(1);
            if (st.step_index >= RampLast) begin
              st.step_index = '0;
              st.led_reg[5] = 1'b1;
              st.led_reg[0] = 1'b1;
              st.mode       = MODE_ON;
            end
          end
        end
      end else if (st.mode == MODE_FLASH) begin
        if (st.flash_count > FlashW'(1)) begin
          st.flash_count = st.flash_count - FlashW'(1);
        end else begin
          st.flash_count = '0;
          st.led_reg     = st.led_reg & ~flash_bit(st.choice_index);
          st.mode        = MODE_OFF;
          if (st.direct_pending) begin
            st.mode           = MODE_ON;
            st.on_flag        = 1'b1;
            st.led_reg        = '1;
            st.direct_pending = 1'b0;
          end
        end
      end
    end

    // direct press: toggle, or hold until the ramp or flash settles
    if (evt_i.direct_press) begin
      if (st.mode == MODE_RAMP || st.mode == MODE_FLASH) begin
        st.direct_pending = 1'b1;
      end else if (st.on_flag) begin
        st.mode           = MODE_OFF;
        st.on_flag        = 1'b0;
        st.led_reg        = '0;
        st.direct_pending = 1'b0;
      end else begin
        st.mode           = MODE_ON;
        st.on_flag        = 1'b1;
        st.led_reg        = '1;
        st.direct_pending = 1'b0;
      end
    end

    // time press while fully off: next preset and start the flash
    if (evt_i.time_press && st.mode == MODE_OFF && !st.on_flag) begin
      st.choice_index = st.choice_index + ChoiceW'(1);
      st.led_reg      = st.led_reg | flash_bit(st.choice_index);
      st.flash_count  = (cfg_i.flash_ms == '0) ? FlashW'(1) : cfg_i.flash_ms;
      st.mode         = MODE_FLASH;
    end

    // soft press: off when on, start the ramp when off
    if (evt_i.soft_press) begin
      if (st.mode == MODE_ON || (st.mode == MODE_OFF && st.on_flag)) begin
        st.mode           = MODE_OFF;
        st.on_flag        = 1'b0;
        st.led_reg        = '0;
        st.direct_pending = 1'b0;
      end else if (st.mode == MODE_OFF) begin
        st.mode           = MODE_RAMP;
        st.on_flag        = 1'b1;
        st.step_index     = '0;
        st.period_repeat  = '0;
        st.ms_in_period   = '0;
        st.direct_pending = 1'b0;
      end
    end
  end

  // pwm bit is high for the first step_index ms of each period
  always_comb begin
    leds = st.led_reg;
    if (st.mode == MODE_RAMP && st.ms_in_period < st.step_index) begin
      leds[0] = 1'b1;
    end
  end

  assign state_o              = st;
  assign result_o.led_bits    = leds;
  assign result_o.running     = st.on_flag;
  assign result_o.ramping     = (st.mode == MODE_RAMP);
  assign result_o.flashing    = (st.mode == MODE_FLASH);
  assign result_o.time_choice = st.choice_index;

endmodule

FILE: design/pwm_soft_start_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_soft_start_sequencer
// Push-button controller for one PWM output with a soft start ramp and
// five indicator LEDs, stepped by 1 ms ticks carried on the input stream.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one word per event slot: tick, direct, soft and
//   time press bits. Every accepted word yields exactly one master word with
//   the LED pattern and status after that word has been applied.
//   The result is registered: it appears on the master side in the cycle
//   after acceptance. Throughput is one word per cycle; the single output
//   register is refilled in the same cycle it is drained, so s_axis_tready
//   only drops while a result is held and m_axis_tready is low.
//   The configuration channel writes the four ramp presets (periods per
//   step) and the flash length in ms; it is always ready and should be
//   used only while no result is pending.
//   Reset puts the output off, selects the first preset, loads the preset
//   defaults and empties the output register.
//   A stalled receiver holds the result word stable and back-pressures the
//   input; no event word is lost or repeated.
// ----------------------------------------------------------------------------
module pwm_soft_start_sequencer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // slave stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: tick_ms, direct_press, soft_press, time_press, 4 zero bits
  input  logic [pss_pkg::InDataW-1:0]      s_axis_tdata,
  // master stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata: led_bits[5:0], running, ramping, flashing, time_choice[1:0], 5 zero bits
  output logic [pss_pkg::OutDataW-1:0]     m_axis_tdata,
  // configuration write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [pss_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [pss_pkg::CfgDataW-1:0]     cfg_data_i
);
  import pss_pkg::*;

  state_t   state_q, state_d;
  cfg_t     cfg_q;
  evt_t     evt;
  result_t  result_d, result_q;
  logic     out_valid_q;
  logic     in_fire;

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !out_valid_q || m_axis_tready;

  // unpack the event word
  assign evt.tick_ms      = s_axis_tdata[0];
  assign evt.direct_press = s_axis_tdata[1];
  assign evt.soft_press   = s_axis_tdata[2];
  assign evt.time_press   = s_axis_tdata[3];

  pss_step u_step (
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .evt_i    (evt),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.presets[0] <= PresetARst;
      cfg_q.presets[1] <= PresetBRst;
      cfg_q.presets[2] <= PresetCRst;
      cfg_q.presets[3] <= PresetDRst;
      cfg_q.flash_ms   <= FlashMsRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_PRESET_A: cfg_q.presets[0] <= cfg_data_i[RepeatW-1:0];
        REG_PRESET_B: cfg_q.presets[1] <= cfg_data_i[RepeatW-1:0];
        REG_PRESET_C: cfg_q.presets[2] <= cfg_data_i[RepeatW-1:0];
        REG_PRESET_D: cfg_q.presets[3] <= cfg_data_i[RepeatW-1:0];
        REG_FLASH_MS: cfg_q.flash_ms   <= cfg_data_i[FlashW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode           <= MODE_OFF;
      state_q.on_flag        <= 1'b0;
      state_q.step_index     <= '0;
      state_q.period_repeat  <= '0;
      state_q.ms_in_period   <= '0;
      state_q.flash_count    <= '0;
      state_q.choice_index   <= '0;
      state_q.direct_pending <= 1'b0;
      state_q.led_reg        <= '0;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - $bits(result_t)){1'b0}}, result_q};

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PWM soft start sequencer. Event words (tick,
// direct, soft and time presses) go in on the slave stream. A status
// scoreboard keeps its own copy of the controller state and predicts one
// status word per event. Each status word on the master stream is checked
// field by field against the oldest prediction. Both sides idle at random,
// and the ramp and flash registers are reloaded between phases, their
// extremes among them.
// ----------------------------------------------------------------------------
module tb_top;
  import pss_pkg::*;

  // event word bits, in tdata order
  localparam logic [3:0] EV_NONE   = 4'b0000;
  localparam logic [3:0] EV_TICK   = 4'b0001;
  localparam logic [3:0] EV_DIRECT = 4'b0010;
  localparam logic [3:0] EV_SOFT   = 4'b0100;
  localparam logic [3:0] EV_TIME   = 4'b1000;

  localparam int unsigned StatusW = $bits(result_t);

  // status scoreboard: predicts the status word for each accepted event
  class status_scoreboard;
    logic [RepeatW-1:0] periods [4];
    logic [FlashW-1:0]  flash_len;
    mode_e              mode;
    logic               on_flag;
    logic [StepW-1:0]   step;
    logic [RepeatW-1:0] rep_cnt;
    logic [MsW-1:0]     ms_cnt;
    logic [FlashW-1:0]  flash_left;
    logic [ChoiceW-1:0] choice;
    logic               direct_wait;
    logic [LedW-1:0]    leds;
    result_t            expected_status [$];
    int                 mismatches;

    function new();
      periods     = '{PresetARst, PresetBRst, PresetCRst, PresetDRst};
      flash_len   = FlashMsRst;
      mode        = MODE_OFF;
      on_flag     = 1'b0;
      step        = '0;
      rep_cnt     = '0;
      ms_cnt      = '0;
      flash_left  = '0;
      choice      = '0;
      direct_wait = 1'b0;
      leds        = '0;
      mismatches  = 0;
    endfunction

    function void take_reg(reg_idx_e idx, logic [CfgDataW-1:0] val);
      if (idx == REG_FLASH_MS) begin
        flash_len = val[FlashW-1:0];
      end else begin
        periods[int'(idx)] = val[RepeatW-1:0];
      end
    endfunction

    function int pending();
      return expected_status.size();
    endfunction

    // indicator LED lit for a newly selected time choice
    function logic [LedW-1:0] indicator(logic [ChoiceW-1:0] c);
      return LedW'(1) << ((c == 2'd0) ? 2 : 6 - int'(c));
    endfunction

    function void turn_off();
      mode        = MODE_OFF;
      on_flag     = 1'b0;
      leds        = '0;
      direct_wait = 1'b0;
    endfunction

    function void turn_on();
      mode        = MODE_ON;
      on_flag     = 1'b1;
      leds        = '1;
      direct_wait = 1'b0;
    endfunction

    // one ms of the ramp: period end, step end, bar LEDs, ramp end
    function void ramp_tick();
      if (ms_cnt < RampLast) begin
        ms_cnt++;
        return;
      end
      ms_cnt = '0;
      if (direct_wait) begin
        turn_off();
        return;
      end
      // a zero preset behaves as one period per step
      if (int'(rep_cnt) + 1 < int'(periods[choice])) begin
        rep_cnt++;
        return;
      end
      rep_cnt = '0;
      if (step <= Bar1Max) begin
        leds[1] = 1'b1;
      end else if (step <= Bar2Max) begin
        leds[2] = 1'b1;
      end else if (step <= Bar3Max) begin
        leds[3] = 1'b1;
      end else if (step <= Bar4Max) begin
        leds[4] = 1'b1;
      end
      step++;
      if (step >= RampLast) begin
        step    = '0;
        leds[0] = 1'b1;
        leds[5] = 1'b1;
        mode    = MODE_ON;
      end
    endfunction

    // one ms of the indicator flash
    function void flash_tick();
      if (flash_left > 1) begin
        flash_left--;
        return;
      end
      flash_left = '0;
      leds &= ~indicator(choice);
      mode = MODE_OFF;
      if (direct_wait) turn_on();
    endfunction

    // apply one event word and queue the status it should produce
    function void note_event(evt_t ev);
      result_t r;
      if (ev.tick_ms) begin
        if (mode == MODE_RAMP) ramp_tick();
        else if (mode == MODE_FLASH) flash_tick();
      end
      if (ev.direct_press) begin
        if (mode == MODE_RAMP || mode == MODE_FLASH) direct_wait = 1'b1;
        else if (on_flag) turn_off();
        else turn_on();
      end
      if (ev.time_press && mode == MODE_OFF && !on_flag) begin
        choice++;
        leds |= indicator(choice);
        // a zero flash length behaves as one ms
        flash_left = (flash_len == '0) ? FlashW'(1) : flash_len;
        mode = MODE_FLASH;
      end
      if (ev.soft_press) begin
        if (mode == MODE_ON || (mode == MODE_OFF && on_flag)) begin
          turn_off();
        end else if (mode == MODE_OFF) begin
          mode        = MODE_RAMP;
          on_flag     = 1'b1;
          step        = '0;
          rep_cnt     = '0;
          ms_cnt      = '0;
          direct_wait = 1'b0;
        end
      end
      r.led_bits = leds;
      if (mode == MODE_RAMP && ms_cnt < step) r.led_bits[0] = 1'b1;
      r.running     = on_flag;
      r.ramping     = (mode == MODE_RAMP);
      r.flashing    = (mode == MODE_FLASH);
      r.time_choice = choice;
      expected_status.push_back(r);
    endfunction

    function void compare(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        end
      end
    endfunction

    function void check_status(logic [OutDataW-1:0] word);
      result_t got;
      result_t want;
      got = result_t'(word[StatusW-1:0]);
      if (expected_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: status word %h with nothing expected", $time, word);
        end
        return;
      end
      want = expected_status.pop_front();
      compare("led_bits", want.led_bits, got.led_bits);
      compare("running", want.running, got.running);
      compare("ramping", want.ramping, got.ramping);
      compare("flashing", want.flashing, got.flashing);
      compare("time_choice", want.time_choice, got.time_choice);
      compare("pad bits", 0, word[OutDataW-1:StatusW]);
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;   // tick_ms, direct_press, soft_press, time_press
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;   // led_bits, running, ramping, flashing, time_choice
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  status_scoreboard board;
  int events_sent   = 0;
  int results_taken = 0;

  pwm_soft_start_sequencer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  // status word monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      board.check_status(m_axis_tdata);
      results_taken++;
    end
  end

  // receiver: random stalls, one quiet stretch and one long hold-off
  initial begin : status_sink
    int  hold_left;
    bit  held;
    hold_left = 0;
    held      = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && results_taken >= 300) begin
        held      = 1'b1;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (results_taken >= 600 && results_taken < 900) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 8);
      end
    end
  end

  // random event word, weighted by the predicted mode so ramps mostly finish
  function automatic evt_t random_event();
    evt_t ev;
    ev = evt_t'(EV_NONE);
    ev.soft_press = ($urandom_range(99) < 3);
    ev.time_press = ($urandom_range(99) < 3);
    if (board.mode == MODE_RAMP) begin
      ev.tick_ms      = ($urandom_range(99) < 85);
      ev.direct_press = ($urandom_range(399) == 0);
    end else begin
      ev.tick_ms      = ($urandom_range(99) < 75);
      ev.direct_press = ($urandom_range(99) < 3);
    end
    if (board.mode == MODE_OFF && !board.on_flag && $urandom_range(99) < 3) begin
      ev.soft_press = 1'b1;
    end
    return ev;
  endfunction

  // offer one event word, random when pick is set
  task automatic send(input bit pick, input logic [3:0] bits);
    evt_t ev;
    if (!(events_sent >= 600 && events_sent < 900) && $urandom_range(99) < 8) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    @(negedge clk_i);
    ev = pick ? random_event() : evt_t'(bits);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataW'(ev);
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_event(ev);
    events_sent++;
  endtask

  // stop offering and wait for every predicted status word
  task automatic quiesce();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic load_reg(input reg_idx_e idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.take_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic configure(input int pa, input int pb, input int pc, input int pd,
                           input int fl);
    quiesce();
    load_reg(REG_PRESET_A, CfgDataW'(pa));
    load_reg(REG_PRESET_B, CfgDataW'(pb));
    load_reg(REG_PRESET_C, CfgDataW'(pc));
    load_reg(REG_PRESET_D, CfgDataW'(pd));
    load_reg(REG_FLASH_MS, CfgDataW'(fl));
  endtask

  // bring the controller back to plain off
  task automatic park_off();
    while (board.mode != MODE_OFF || board.on_flag) begin
      if (board.mode == MODE_RAMP) send(1'b0, EV_TICK | EV_DIRECT);
      else if (board.mode == MODE_FLASH) send(1'b0, EV_TICK);
      else send(1'b0, EV_DIRECT);
    end
  endtask

  task automatic random_phase(input int count, input bit pause_midway);
    for (int i = 0; i < count; i++) begin
      if (pause_midway && i == count / 2) quiesce();
      send(1'b1, EV_NONE);
    end
  endtask

  // stimulus
  initial begin : event_source
    board         = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_PRESET_A;
    cfg_data_i    = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: short presets, a zero preset and a zero flash length
    configure(1, 2, 3, 0, 0);
    send(1'b0, EV_NONE);
    send(1'b0, EV_DIRECT);                // on
    send(1'b0, EV_TIME);                  // ignored while on
    send(1'b0, EV_SOFT);                  // soft press while on turns off
    send(1'b0, EV_DIRECT);
    send(1'b0, EV_DIRECT);
    send(1'b0, EV_DIRECT | EV_SOFT);      // on, then off in the same word
    send(1'b0, EV_TIME);                  // flash for choice one
    send(1'b0, EV_DIRECT);                // remembered during the flash
    send(1'b0, EV_SOFT | EV_TIME);        // ignored during the flash
    send(1'b0, EV_TICK);                  // flash ends, output fully on
    send(1'b0, EV_TICK | EV_DIRECT | EV_SOFT | EV_TIME);
    send(1'b0, EV_TICK);
    for (int c = 0; c < 5; c++) begin     // walk the choices round to preset d
      send(1'b0, EV_TIME);
      send(1'b0, EV_TICK);
    end
    send(1'b0, EV_SOFT);                  // full ramp on the zero preset
    while (board.mode == MODE_RAMP) send(1'b0, EV_TICK);
    send(1'b0, EV_DIRECT);
    send(1'b0, EV_SOFT);                  // ramp aborted by a direct press
    repeat (5) send(1'b0, EV_TICK);
    send(1'b0, EV_DIRECT);
    send(1'b0, EV_SOFT | EV_TIME);
    while (board.mode == MODE_RAMP) send(1'b0, EV_TICK);

    // random, small presets
    configure($urandom_range(2, 1), $urandom_range(2, 1), $urandom_range(2, 1),
              $urandom_range(2, 1), $urandom_range(40, 1));
    random_phase(450, 1'b1);

    // random, lowest register values
    park_off();
    configure(1, 1, 1, 1, 1);
    random_phase(450, 1'b0);

    // highest register values: an aborted long ramp
    park_off();
    configure(255, 255, 255, 255, 4095);
    send(1'b0, EV_SOFT);
    repeat (60) send(1'b0, EV_TICK);
    send(1'b0, EV_DIRECT);
    while (board.mode == MODE_RAMP) send(1'b0, EV_TICK);

    // random, mixed presets
    configure($urandom_range(3, 1), $urandom_range(3, 1), $urandom_range(3, 1),
              $urandom_range(3, 1), $urandom_range(60, 1));
    random_phase(450, 1'b0);

    // drain and report
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
